[rtl/core/thermal_level_frequency_capper_defines.svh]
// ----------------------------------------------------------------------------
// Thermal level frequency capper assertion macros
// Shared assertion shorthands, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef THERMAL_LEVEL_FREQUENCY_CAPPER_DEFINES_SVH
`define THERMAL_LEVEL_FREQUENCY_CAPPER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TLFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define TLFC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/core/tlfc_pkg.sv]
// ----------------------------------------------------------------------------
// Thermal level frequency capper package
// Widths, codes, the cap table and the types shared by the capper modules.
// ----------------------------------------------------------------------------
package tlfc_pkg;

	localparam int NUM_DOMAINS = 3;
	localparam int DWELL_W     = 16;
	localparam int FREQ_W      = 23;
	localparam int CAP_W       = 31;
	localparam int TEMP_W      = 12;
	localparam int CFG_IDX_W   = 3;

	localparam logic [CAP_W-1:0]   CAP_UNLIMITED = 31'h7FFF_FFFF;
	localparam logic [DWELL_W-1:0] DWELL_MAX     = 16'hFFFF;
	localparam logic [DWELL_W-1:0] DWELL_RESET   = 16'd20;
	localparam logic [FREQ_W-1:0]  HW_MAX_RESET  = 23'd8000000;

	localparam logic signed [TEMP_W-1:0] WARM_ENTER  = 12'sd380;
	localparam logic signed [TEMP_W-1:0] WARM_EXIT   = 12'sd370;
	localparam logic signed [TEMP_W-1:0] HOT_ENTER   = 12'sd400;
	localparam logic signed [TEMP_W-1:0] HOT_EXIT    = 12'sd390;
	localparam logic signed [TEMP_W-1:0] TEMP_REJECT = 12'sd900;
	localparam logic signed [TEMP_W-1:0] TEMP_ZERO   = 12'sd0;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_APPLY  = 2'd2;
	localparam logic [1:0] CMD_NONE   = 2'd3;

	localparam logic [1:0] LVL_NORMAL = 2'd0;
	localparam logic [1:0] LVL_WARM   = 2'd1;
	localparam logic [1:0] LVL_HOT    = 2'd2;

	localparam logic [1:0] TIER_LIGHT    = 2'd0;
	localparam logic [1:0] TIER_MODERATE = 2'd1;
	localparam logic [1:0] TIER_HEAVY    = 2'd2;
	localparam logic [1:0] TIER_INVALID  = 2'd3;

	localparam logic [1:0] WL_OTHER       = 2'd0;
	localparam logic [1:0] WL_INTERACTIVE = 2'd1;
	localparam logic [1:0] WL_SUSTAINED   = 2'd2;
	localparam logic [1:0] WL_FRAME       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_PERF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_D0_MIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_D0_MAX    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_D1_MIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_D1_MAX    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_D2_MIN    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_D2_MAX    = 3'd7;

	typedef struct packed {
		logic       emit;
		logic       status;
		logic [1:0] level;
		logic [1:0] tier;
	} level_info_t;

	typedef struct packed {
		logic                               status;
		logic [NUM_DOMAINS-1:0]             mask;
		logic [NUM_DOMAINS-1:0][CAP_W-1:0]  cap;
		logic [1:0]                         tier;
		logic [1:0]                         level;
	} result_t;

	function automatic logic [CAP_W-1:0] cap_lookup(logic [1:0] level, logic [1:0] tier,
			logic [1:0] dom);
		logic [CAP_W-1:0] v;
		unique case ({level, tier, dom})
			{LVL_NORMAL, TIER_LIGHT,    2'd0}: v = 31'd1200000;
			{LVL_NORMAL, TIER_LIGHT,    2'd1}: v = 31'd1600000;
			{LVL_NORMAL, TIER_LIGHT,    2'd2}: v = 31'd1600000;
			{LVL_NORMAL, TIER_MODERATE, 2'd0}: v = 31'd1800000;
			{LVL_NORMAL, TIER_MODERATE, 2'd1}: v = 31'd2500000;
			{LVL_NORMAL, TIER_MODERATE, 2'd2}: v = 31'd2600000;
			{LVL_NORMAL, TIER_HEAVY,    2'd0}: v = CAP_UNLIMITED;
			{LVL_NORMAL, TIER_HEAVY,    2'd1}: v = CAP_UNLIMITED;
			{LVL_NORMAL, TIER_HEAVY,    2'd2}: v = CAP_UNLIMITED;
			{LVL_WARM,   TIER_LIGHT,    2'd0}: v = 31'd1200000;
			{LVL_WARM,   TIER_LIGHT,    2'd1}: v = 31'd1600000;
			{LVL_WARM,   TIER_LIGHT,    2'd2}: v = 31'd1400000;
			{LVL_WARM,   TIER_MODERATE, 2'd0}: v = 31'd1700000;
			{LVL_WARM,   TIER_MODERATE, 2'd1}: v = 31'd2400000;
			{LVL_WARM,   TIER_MODERATE, 2'd2}: v = 31'd2500000;
			{LVL_WARM,   TIER_HEAVY,    2'd0}: v = 31'd1900000;
			{LVL_WARM,   TIER_HEAVY,    2'd1}: v = 31'd2700000;
			{LVL_WARM,   TIER_HEAVY,    2'd2}: v = 31'd2800000;
			{LVL_HOT,    TIER_LIGHT,    2'd0}: v = 31'd1100000;
			{LVL_HOT,    TIER_LIGHT,    2'd1}: v = 31'd1500000;
			{LVL_HOT,    TIER_LIGHT,    2'd2}: v = 31'd1200000;
			{LVL_HOT,    TIER_MODERATE, 2'd0}: v = 31'd1500000;
			{LVL_HOT,    TIER_MODERATE, 2'd1}: v = 31'd2100000;
			{LVL_HOT,    TIER_MODERATE, 2'd2}: v = 31'd2200000;
			{LVL_HOT,    TIER_HEAVY,    2'd0}: v = 31'd1700000;
			{LVL_HOT,    TIER_HEAVY,    2'd1}: v = 31'd2400000;
			{LVL_HOT,    TIER_HEAVY,    2'd2}: v = 31'd2500000;
			default:                           v = CAP_UNLIMITED;
		endcase
		return v;
	endfunction

endpackage

[rtl/core/tlfc_level.sv]
// ----------------------------------------------------------------------------
// Thermal level tracker
// Holds the thermal level and dwell counter and resolves the effective tier.
// ----------------------------------------------------------------------------
module tlfc_level (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  logic [1:0]                           command,
	input  logic signed [tlfc_pkg::TEMP_W-1:0]   temp_deci_c,
	input  logic [1:0]                           tier_in,
	input  logic [1:0]                           workload_state,
	input  logic [tlfc_pkg::DWELL_W-1:0]         release_dwell_ticks,
	output tlfc_pkg::level_info_t                info
);

	logic [1:0]                   level_q;
	logic [tlfc_pkg::DWELL_W-1:0] dwell_q;
	logic [1:0]                   level_next;
	logic                         reject;
	logic                         dwell_done;
	logic                         is_sample;
	logic [1:0]                   tier;

	assign is_sample  = (command == tlfc_pkg::CMD_SAMPLE);
	assign reject     = (temp_deci_c <= tlfc_pkg::TEMP_ZERO) ||
			(temp_deci_c >= tlfc_pkg::TEMP_REJECT);
	assign dwell_done = (dwell_q >= release_dwell_ticks);

	always_comb begin
		level_next = level_q;
		if (is_sample && !reject) begin
			unique case (level_q)
				tlfc_pkg::LVL_NORMAL: begin
					if (temp_deci_c >= tlfc_pkg::HOT_ENTER)
						level_next = tlfc_pkg::LVL_HOT;
					else if (temp_deci_c >= tlfc_pkg::WARM_ENTER)
						level_next = tlfc_pkg::LVL_WARM;
				end
				tlfc_pkg::LVL_WARM: begin
					if (temp_deci_c >= tlfc_pkg::HOT_ENTER)
						level_next = tlfc_pkg::LVL_HOT;
					else if (temp_deci_c <= tlfc_pkg::WARM_EXIT && dwell_done)
						level_next = tlfc_pkg::LVL_NORMAL;
				end
				tlfc_pkg::LVL_HOT: begin
					if (temp_deci_c <= tlfc_pkg::HOT_EXIT && dwell_done)
						level_next = (temp_deci_c <= tlfc_pkg::WARM_EXIT) ?
								tlfc_pkg::LVL_NORMAL : tlfc_pkg::LVL_WARM;
				end
				default: level_next = tlfc_pkg::LVL_NORMAL;
			endcase
		end
	end

	always_comb begin
		tier = tier_in;
		if (workload_state == tlfc_pkg::WL_INTERACTIVE && tier == tlfc_pkg::TIER_LIGHT)
			tier = tlfc_pkg::TIER_MODERATE;
		if (workload_state == tlfc_pkg::WL_SUSTAINED || workload_state == tlfc_pkg::WL_FRAME)
			tier = tlfc_pkg::TIER_HEAVY;
		if (tier == tlfc_pkg::TIER_INVALID)
			tier = tlfc_pkg::TIER_LIGHT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= tlfc_pkg::LVL_NORMAL;
			dwell_q <= '0;
		end else if (fire) begin
			if (command == tlfc_pkg::CMD_TICK) begin
				if (dwell_q != tlfc_pkg::DWELL_MAX)
					dwell_q <= dwell_q + 1'b1;
			end else if (level_next != level_q) begin
				level_q <= level_next;
				dwell_q <= '0;
			end
		end
	end

	assign info.emit   = (command == tlfc_pkg::CMD_SAMPLE) || (command == tlfc_pkg::CMD_APPLY);
	assign info.status = is_sample && reject;
	assign info.level  = level_next;
	assign info.tier   = tier;

endmodule

[rtl/core/tlfc_lane.sv]
// ----------------------------------------------------------------------------
// Domain cap lane
// Clamps one domain's table cap, applies its floor and tracks the applied cap.
// ----------------------------------------------------------------------------
module tlfc_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          apply,
	input  logic                          hp_mode,
	input  logic [tlfc_pkg::CAP_W-1:0]    table_cap,
	input  logic [tlfc_pkg::FREQ_W-1:0]   hw_min,
	input  logic [tlfc_pkg::FREQ_W-1:0]   hw_max,
	input  logic [tlfc_pkg::FREQ_W-1:0]   floor_khz,
	output logic [tlfc_pkg::CAP_W-1:0]    cap,
	output logic                          changed
);

	logic [tlfc_pkg::CAP_W-1:0]  applied_q;
	logic [tlfc_pkg::FREQ_W-1:0] lim_a;
	logic [tlfc_pkg::FREQ_W-1:0] lim_b;
	logic [tlfc_pkg::FREQ_W-1:0] lim_c;

	// Limited table entries all fit in the frequency width.
	always_comb begin
		lim_a = table_cap[tlfc_pkg::FREQ_W-1:0];
		if (lim_a < hw_min)
			lim_a = hw_min;
		lim_b = (lim_a > hw_max) ? hw_max : lim_a;
		lim_c = (floor_khz > lim_b) ? floor_khz : lim_b;
	end

	always_comb begin
		priority if (hp_mode || table_cap == tlfc_pkg::CAP_UNLIMITED)
			cap = tlfc_pkg::CAP_UNLIMITED;
		else
			cap = {{(tlfc_pkg::CAP_W - tlfc_pkg::FREQ_W){1'b0}}, lim_c};
	end

	assign changed = (cap != applied_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			applied_q <= tlfc_pkg::CAP_UNLIMITED;
		else if (apply)
			applied_q <= cap;
	end

endmodule

[rtl/core/tlfc_out.sv]
// ----------------------------------------------------------------------------
// Result output stage
// Output register with a skid entry so the input side runs while results wait.
// ----------------------------------------------------------------------------
module tlfc_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tlfc_pkg::result_t in_res,
	input  logic              out_ready,
	output logic              out_valid,
	output tlfc_pkg::result_t out_res,
	output logic              full
);

	logic              out_valid_q;
	logic              skid_valid_q;
	tlfc_pkg::result_t out_res_q;
	tlfc_pkg::result_t skid_res_q;
	logic              drain;

	assign drain = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_valid_q)
				out_res_q <= skid_res_q;
			else if (in_valid)
				out_res_q <= in_res;
		end else if (in_valid) begin
			skid_res_q <= in_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;
	assign full      = skid_valid_q;

endmodule

[rtl/core/thermal_level_frequency_capper.sv]
// ----------------------------------------------------------------------------
// Thermal level frequency capper
// Thermal level tracking with per-domain frequency caps for three CPU domains.
// ----------------------------------------------------------------------------
// The block takes one item in every cycle while s_axis_tready is high and
// resolves it in that cycle: the thermal level update, the tier rules and
// the three domain lanes are all combinational logic, and each result is
// then registered. Results pass through an output register backed by one
// skid entry; s_axis_tready falls only when both are full, that is when a
// second result arrives while the first is still held back. Ticks and unused
// commands give no result. Configuration writes are always taken at once.
// ----------------------------------------------------------------------------
`include "thermal_level_frequency_capper_defines.svh"

module thermal_level_frequency_capper (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// temp_deci_c, load tier, workload_state, floor0_khz, floor1_khz, floor2_khz
	input  logic [87:0]  s_axis_tdata,
	// command
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// level, effective_tier, cap0_khz, cap1_khz, cap2_khz, changed_mask
	output logic [103:0] m_axis_tdata,
	// status
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [22:0]  cfg_data
);

	localparam int NDOM = tlfc_pkg::NUM_DOMAINS;
	localparam int FW   = tlfc_pkg::FREQ_W;
	localparam int FLOOR_LSB = 16;

	logic                                high_perf_q;
	logic [tlfc_pkg::DWELL_W-1:0]        dwell_ticks_q;
	logic [NDOM-1:0][FW-1:0]             hw_min_q;
	logic [NDOM-1:0][FW-1:0]             hw_max_q;

	logic                                s_fire;
	logic                                apply;
	logic                                skid_full;
	tlfc_pkg::level_info_t               info;
	tlfc_pkg::result_t                   res;
	tlfc_pkg::result_t                   out_res;
	logic [NDOM-1:0][tlfc_pkg::CAP_W-1:0] table_cap;
	logic [NDOM-1:0][tlfc_pkg::CAP_W-1:0] lane_cap;
	logic [NDOM-1:0]                     lane_changed;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_perf_q   <= 1'b0;
			dwell_ticks_q <= tlfc_pkg::DWELL_RESET;
			hw_min_q      <= '0;
			hw_max_q      <= {NDOM{tlfc_pkg::HW_MAX_RESET}};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tlfc_pkg::REG_HIGH_PERF: high_perf_q   <= cfg_data[0];
				tlfc_pkg::REG_DWELL:     dwell_ticks_q <= cfg_data[tlfc_pkg::DWELL_W-1:0];
				tlfc_pkg::REG_D0_MIN:    hw_min_q[0]   <= cfg_data;
				tlfc_pkg::REG_D0_MAX:    hw_max_q[0]   <= cfg_data;
				tlfc_pkg::REG_D1_MIN:    hw_min_q[1]   <= cfg_data;
				tlfc_pkg::REG_D1_MAX:    hw_max_q[1]   <= cfg_data;
				tlfc_pkg::REG_D2_MIN:    hw_min_q[2]   <= cfg_data;
				tlfc_pkg::REG_D2_MAX:    hw_max_q[2]   <= cfg_data;
			endcase
		end
	end

	assign s_axis_tready = !skid_full;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign apply         = s_fire && info.emit;

	tlfc_level u_level (
		.clk                 (clk),
		.arst_n              (arst_n),
		.fire                (s_fire),
		.command             (s_axis_tuser),
		.temp_deci_c         (s_axis_tdata[11:0]),
		.tier_in             (s_axis_tdata[13:12]),
		.workload_state      (s_axis_tdata[15:14]),
		.release_dwell_ticks (dwell_ticks_q),
		.info                (info)
	);

	for (genvar g = 0; g < NDOM; g++) begin : g_lane
		assign table_cap[g] = tlfc_pkg::cap_lookup(info.level, info.tier, 2'(g));

		tlfc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.apply     (apply),
			.hp_mode   (high_perf_q),
			.table_cap (table_cap[g]),
			.hw_min    (hw_min_q[g]),
			.hw_max    (hw_max_q[g]),
			.floor_khz (s_axis_tdata[FLOOR_LSB + FW*g +: FW]),
			.cap       (lane_cap[g]),
			.changed   (lane_changed[g])
		);
	end

	assign res.status = info.status;
	assign res.mask   = lane_changed;
	assign res.cap    = lane_cap;
	assign res.tier   = info.tier;
	assign res.level  = info.level;

	tlfc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (apply),
		.in_res    (res),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.full      (skid_full)
	);

	assign m_axis_tdata = {4'b0000, out_res.mask, out_res.cap[2], out_res.cap[1],
			out_res.cap[0], out_res.tier, out_res.level};
	assign m_axis_tuser = out_res.status;

	`TLFC_ASSERT(a_skid_behind_out, skid_full |-> m_axis_tvalid, "skid entry held without output")
	`TLFC_ASSERT(a_tick_no_result, (s_fire && s_axis_tuser == tlfc_pkg::CMD_TICK && !m_axis_tvalid) |=> !m_axis_tvalid, "tick produced a result")
	`TLFC_ASSERT(a_hp_unlimited, (apply && high_perf_q && (!m_axis_tvalid || m_axis_tready)) |=> (out_res.cap[0] == tlfc_pkg::CAP_UNLIMITED && out_res.cap[1] == tlfc_pkg::CAP_UNLIMITED && out_res.cap[2] == tlfc_pkg::CAP_UNLIMITED), "cap limited in high performance mode")
	`TLFC_NEVER(a_tier_valid, m_axis_tvalid && out_res.tier == tlfc_pkg::TIER_INVALID, "invalid tier in result")

endmodule

[tb/sv/tlfc_cap_checker.sv]
// ----------------------------------------------------------------------------
// Thermal level frequency capper checker
// Watches the item, result and register channels of the capper, predicts the
// level, tier and domain caps of every accepted sample or apply item and
// compares each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tlfc_cap_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [87:0]  s_axis_tdata,
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [22:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           items_in,
	output int           results_seen
);
	import tlfc_pkg::*;

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [1:0]                        level;
		logic [1:0]                        tier;
		logic [NUM_DOMAINS-1:0][CAP_W-1:0] cap;
		logic [NUM_DOMAINS-1:0]            mask;
		logic                              status;
	} cap_result_t;

	// Indexed by level * 9 + tier * 3 + domain.
	localparam logic [0:26][CAP_W-1:0] CAP_GRID = {
		31'd1200000, 31'd1600000, 31'd1600000,
		31'd1800000, 31'd2500000, 31'd2600000,
		CAP_UNLIMITED, CAP_UNLIMITED, CAP_UNLIMITED,
		31'd1200000, 31'd1600000, 31'd1400000,
		31'd1700000, 31'd2400000, 31'd2500000,
		31'd1900000, 31'd2700000, 31'd2800000,
		31'd1100000, 31'd1500000, 31'd1200000,
		31'd1500000, 31'd2100000, 31'd2200000,
		31'd1700000, 31'd2400000, 31'd2500000
	};

	logic               hi_perf;
	logic [DWELL_W-1:0] dwell_need;
	logic [DWELL_W-1:0] dwell_cnt;
	logic [FREQ_W-1:0]  hw_lo [NUM_DOMAINS];
	logic [FREQ_W-1:0]  hw_hi [NUM_DOMAINS];
	logic [1:0]         lvl;
	logic [CAP_W-1:0]   applied [NUM_DOMAINS];
	cap_result_t        results_due [$];

	function automatic void predict_caps(input logic [1:0] cmd, input logic [87:0] d);
		logic signed [TEMP_W-1:0] t;
		logic [1:0]               tier;
		logic [1:0]               wl;
		logic [1:0]               nxt;
		logic                     dwell_ok;
		logic [FREQ_W-1:0]        fl;
		logic [CAP_W-1:0]         tgt;
		cap_result_t              r;
		int                       i;
		t = d[11:0];
		tier = d[13:12];
		wl = d[15:14];
		r = '0;
		if (cmd == CMD_TICK) begin
			if (dwell_cnt != DWELL_MAX)
				dwell_cnt = dwell_cnt + 1'b1;
			return;
		end
		if (cmd == CMD_NONE)
			return;
		if (cmd == CMD_SAMPLE) begin
			if (t <= TEMP_ZERO || t >= TEMP_REJECT) begin
				r.status = 1'b1;
			end else begin
				dwell_ok = dwell_cnt >= dwell_need;
				nxt = lvl;
				case (lvl)
					LVL_NORMAL: begin
						if (t >= HOT_ENTER)
							nxt = LVL_HOT;
						else if (t >= WARM_ENTER)
							nxt = LVL_WARM;
					end
					LVL_WARM: begin
						if (t >= HOT_ENTER)
							nxt = LVL_HOT;
						else if (t <= WARM_EXIT && dwell_ok)
							nxt = LVL_NORMAL;
					end
					LVL_HOT: begin
						if (t <= HOT_EXIT && dwell_ok)
							nxt = (t <= WARM_EXIT) ? LVL_NORMAL : LVL_WARM;
					end
					default: nxt = LVL_NORMAL;
				endcase
				if (nxt != lvl) begin
					lvl = nxt;
					dwell_cnt = '0;
				end
			end
		end
		if (wl == WL_INTERACTIVE && tier == TIER_LIGHT)
			tier = TIER_MODERATE;
		if (wl == WL_SUSTAINED || wl == WL_FRAME)
			tier = TIER_HEAVY;
		if (tier == TIER_INVALID)
			tier = TIER_LIGHT;
		for (i = 0; i < NUM_DOMAINS; i++) begin
			fl = d[16 + FREQ_W * i +: FREQ_W];
			if (hi_perf) begin
				tgt = CAP_UNLIMITED;
			end else begin
				tgt = CAP_GRID[9 * int'(lvl) + 3 * int'(tier) + i];
				if (tgt != CAP_UNLIMITED) begin
					if (tgt < CAP_W'(hw_lo[i]))
						tgt = CAP_W'(hw_lo[i]);
					if (tgt > CAP_W'(hw_hi[i]))
						tgt = CAP_W'(hw_hi[i]);
					if (CAP_W'(fl) > tgt)
						tgt = CAP_W'(fl);
				end
			end
			if (tgt != applied[i]) begin
				applied[i] = tgt;
				r.mask[i] = 1'b1;
			end
			r.cap[i] = tgt;
		end
		r.level = lvl;
		r.tier = tier;
		results_due.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int          i;
		cap_result_t got;
		cap_result_t want;
		if (!arst_n) begin
			hi_perf = 1'b0;
			dwell_need = DWELL_RESET;
			dwell_cnt = '0;
			lvl = LVL_NORMAL;
			for (i = 0; i < NUM_DOMAINS; i++) begin
				hw_lo[i] = '0;
				hw_hi[i] = HW_MAX_RESET;
				applied[i] = CAP_UNLIMITED;
			end
			results_due.delete();
			errors = 0;
			pending = 0;
			items_in = 0;
			results_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.level = m_axis_tdata[1:0];
				got.tier = m_axis_tdata[3:2];
				got.cap = m_axis_tdata[96:4];
				got.mask = m_axis_tdata[99:97];
				got.status = m_axis_tuser;
				if (results_due.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: result %0d arrived with nothing expected: level %0d tier %0d",
							$time, results_seen, got.level, got.tier);
				end else begin
					want = results_due.pop_front();
					if (got.level !== want.level || got.tier !== want.tier ||
							got.cap !== want.cap || got.mask !== want.mask ||
							got.status !== want.status) begin
						errors++;
						if (errors <= REPORT_MAX) begin
							$display("%0t: result %0d mismatch", $time, results_seen);
							$display("  expected level %0d tier %0d caps %0d %0d %0d mask %b status %b",
								want.level, want.tier, want.cap[0], want.cap[1], want.cap[2],
								want.mask, want.status);
							$display("  actual   level %0d tier %0d caps %0d %0d %0d mask %b status %b",
								got.level, got.tier, got.cap[0], got.cap[1], got.cap[2],
								got.mask, got.status);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HIGH_PERF: hi_perf = cfg_data[0];
					REG_DWELL:     dwell_need = cfg_data[DWELL_W-1:0];
					REG_D0_MIN:    hw_lo[0] = cfg_data;
					REG_D0_MAX:    hw_hi[0] = cfg_data;
					REG_D1_MIN:    hw_lo[1] = cfg_data;
					REG_D1_MAX:    hw_hi[1] = cfg_data;
					REG_D2_MIN:    hw_lo[2] = cfg_data;
					REG_D2_MAX:    hw_hi[2] = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				items_in++;
				predict_caps(s_axis_tuser, s_axis_tdata);
			end
			pending = results_due.size();
		end
	end

endmodule

[tb/sv/tb_thermal_level_frequency_capper.sv]
// ----------------------------------------------------------------------------
// Thermal level frequency capper testbench
// Drives directed and random items through the capper under several register
// settings and idling patterns, including the longest dwell setting; a
// separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_thermal_level_frequency_capper;
	import tlfc_pkg::*;

	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 188;
	localparam int SETTLE_CYCLES = 4;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [87:0]  s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [22:0]  cfg_data;

	int   errors;
	int   pending;
	int   items_in;
	int   results_seen;
	int   tx_idle = 14;
	int   rx_idle = 84;
	int   settings = 0;
	int   quiet = 0;
	logic s_took = 1'b0;
	logic cfg_took = 1'b0;

	thermal_level_frequency_capper DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	tlfc_cap_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.items_in      (items_in),
		.results_seen  (results_seen)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		s_took <= s_axis_tvalid && s_axis_tready;
		cfg_took <= cfg_valid && cfg_ready;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Timed out after %0d cycles without a handshake.", quiet);
			$display("tb_thermal_level_frequency_capper: done, errors");
			$finish;
		end
	end

	task automatic send_item(input logic [1:0] cmd, input logic [11:0] temp,
			input logic [1:0] tier, input logic [1:0] wl,
			input logic [22:0] f0, input logic [22:0] f1, input logic [22:0] f2);
		while ($urandom_range(99) < tx_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tuser = cmd;
		s_axis_tdata = {3'b000, f2, f1, f0, wl, tier, temp};
		s_axis_tvalid = 1'b1;
		do @(negedge clk); while (!s_took);
	endtask

	task automatic send_simple(input logic [1:0] cmd, input logic [11:0] temp);
		send_item(cmd, temp, TIER_LIGHT, WL_OTHER, '0, '0, '0);
	endtask

	task automatic send_random();
		int          r;
		int          i;
		logic [1:0]  cmd;
		logic [11:0] temp;
		logic [22:0] fl [3];
		r = $urandom_range(99);
		cmd = (r < 35) ? CMD_TICK : (r < 70) ? CMD_SAMPLE : (r < 95) ? CMD_APPLY : CMD_NONE;
		r = $urandom_range(99);
		if (r < 60)
			temp = 12'($urandom_range(410, 360));
		else if (r < 80)
			temp = 12'($urandom_range(899, 1));
		else
			temp = 12'($urandom_range(4095, 0));
		for (i = 0; i < 3; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				fl[i] = '0;
			else if (r < 80)
				fl[i] = 23'($urandom_range(8000000));
			else
				fl[i] = 23'($urandom_range(3000000, 1000000));
		end
		send_item(cmd, temp, 2'($urandom_range(3)), 2'($urandom_range(3)), fl[0], fl[1], fl[2]);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(negedge clk); while (!cfg_took);
		cfg_valid = 1'b0;
	endtask

	task automatic load_setting(input logic hp, input logic [15:0] dwell,
			input logic [22:0] lo0, input logic [22:0] hi0,
			input logic [22:0] lo1, input logic [22:0] hi1,
			input logic [22:0] lo2, input logic [22:0] hi2);
		write_reg(REG_HIGH_PERF, {22'd0, hp});
		write_reg(REG_DWELL, {7'd0, dwell});
		write_reg(REG_D0_MIN, lo0);
		write_reg(REG_D0_MAX, hi0);
		write_reg(REG_D1_MIN, lo1);
		write_reg(REG_D1_MAX, hi1);
		write_reg(REG_D2_MIN, lo2);
		write_reg(REG_D2_MAX, hi2);
		settings++;
	endtask

	task automatic drain_results();
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int          p;
		logic [22:0] v;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_TICK;
		cfg_valid = 1'b0;
		cfg_index = REG_HIGH_PERF;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		load_setting(1'b0, 16'd2, 23'd0, 23'd8000000, 23'd0, 23'd8000000, 23'd0, 23'd8000000);
		send_simple(CMD_APPLY, 12'd0);
		send_item(CMD_APPLY, 12'd0, TIER_INVALID, WL_OTHER, '0, '0, '0);
		send_item(CMD_APPLY, 12'd0, TIER_LIGHT, WL_INTERACTIVE, '0, '0, '0);
		send_item(CMD_APPLY, 12'd0, TIER_INVALID, WL_INTERACTIVE, '0, '0, '0);
		send_item(CMD_APPLY, 12'd0, TIER_MODERATE, WL_SUSTAINED, '0, '0, '0);
		send_item(CMD_APPLY, 12'd0, TIER_LIGHT, WL_FRAME, '0, '0, '0);
		send_simple(CMD_NONE, 12'd500);
		send_simple(CMD_SAMPLE, 12'd0);
		send_simple(CMD_SAMPLE, 12'h800);
		send_simple(CMD_SAMPLE, 12'd900);
		send_simple(CMD_SAMPLE, 12'h7FF);
		send_simple(CMD_SAMPLE, 12'd380);
		send_simple(CMD_SAMPLE, 12'd370);
		send_simple(CMD_TICK, 12'd0);
		send_simple(CMD_TICK, 12'd0);
		send_simple(CMD_SAMPLE, 12'd370);
		send_simple(CMD_SAMPLE, 12'd400);
		send_simple(CMD_TICK, 12'd0);
		send_simple(CMD_TICK, 12'd0);
		send_simple(CMD_SAMPLE, 12'd390);
		send_simple(CMD_SAMPLE, 12'd899);
		send_simple(CMD_TICK, 12'd0);
		send_simple(CMD_TICK, 12'd0);
		send_simple(CMD_SAMPLE, 12'd1);
		send_item(CMD_APPLY, 12'd0, TIER_LIGHT, WL_OTHER,
			23'd8000000, 23'd8000000, 23'd8000000);
		drain_results();

		for (p = 0; p < 8; p++) begin
			if (p == 3) begin
				tx_idle = 84;
				rx_idle = 14;
			end
			if (p == 6) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			v = 23'($urandom_range(3000000, 1000000));
			case (p)
				0: load_setting(1'b0, 16'd0, 23'd0, 23'd8000000, 23'd0, 23'd8000000,
					23'd0, 23'd8000000);
				1: load_setting(1'b0, 16'($urandom_range(6, 1)),
					23'($urandom_range(2000000)), 23'($urandom_range(3000000, 1000000)),
					23'($urandom_range(2000000)), 23'($urandom_range(3000000, 1000000)),
					23'($urandom_range(2000000)), 23'($urandom_range(3000000, 1000000)));
				2: load_setting(1'b0, 16'd3, 23'd8000000, 23'd0, 23'd8000000, 23'd0,
					23'd8000000, 23'd0);
				3: load_setting(1'b1, 16'($urandom_range(6)),
					23'($urandom_range(8000000)), 23'($urandom_range(8000000)),
					23'($urandom_range(8000000)), 23'($urandom_range(8000000)),
					23'($urandom_range(8000000)), 23'($urandom_range(8000000)));
				4: load_setting(1'b0, 16'($urandom_range(20)), v, v, v, v, v, v);
				5: load_setting(1'b0, 16'd20,
					23'($urandom_range(8000000)), 23'($urandom_range(8000000)),
					23'($urandom_range(8000000)), 23'($urandom_range(8000000)),
					23'($urandom_range(8000000)), 23'($urandom_range(8000000)));
				6: load_setting(1'b0, 16'($urandom_range(6)),
					23'($urandom_range(2000000)), 23'($urandom_range(8000000, 2000000)),
					23'd0, 23'd8000000,
					23'($urandom_range(2000000)), 23'($urandom_range(3000000, 1000000)));
				default: load_setting(1'b0, 16'hFFFF, 23'd0, 23'd8000000, 23'd0,
					23'd8000000, 23'd0, 23'd8000000);
			endcase
			repeat (PHASE_ITEMS) send_random();
			drain_results();
		end

		$display("Summary: %0d items accepted, %0d results checked, %0d register settings.",
			items_in, results_seen, settings);
		$display("Covered all commands, hysteresis edges, rejected samples, tier rules, "
			, "inverted ranges, floors, high performance and the longest dwell.");
		if (errors == 0 && pending == 0)
			$display("tb_thermal_level_frequency_capper: done, clean");
		else
			$display("tb_thermal_level_frequency_capper: done, errors");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tlfc_pkg.sv
rtl/core/tlfc_level.sv
rtl/core/tlfc_lane.sv
rtl/core/tlfc_out.sv
rtl/core/thermal_level_frequency_capper.sv
tb/sv/tlfc_cap_checker.sv
tb/sv/tb_thermal_level_frequency_capper.sv
